### rtl/core/etsp_pkg.sv
// Package for the event timer slot pool: command and status codes,
// controller state type and the slot record layout. No dependencies.
package etsp_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_POLL    = 3'd4
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_e;

  // Slot record kept in the slot memory.
  typedef struct packed {
    logic        kind;
    logic        absolute;
    logic        recurring;
    logic [31:0] period;
    logic [31:0] target;
    logic [31:0] due;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

endpackage

### rtl/core/etsp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module etsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/event_timer_slot_pool.sv
// Top level of the event timer slot pool. Uses etsp_pkg and etsp_ram.
// Holds the command sequencer, the active bits and the output register.
//
// Slot records live in one memory with a registered read. Each command is
// handled one at a time, and a new input transaction is taken only once
// the last result of the previous one has left the output register.
// Delete, restart, query and unknown commands pass through S_READ, S_EXEC
// and S_OUT before presenting their result. Create picks the lowest free
// slot from the active bits and goes from S_READ straight to S_OUT. Poll
// reads and checks each slot in turn, alternating S_READ and S_SCAN; a due
// slot holds the scan for as long as the previous result waits for the
// sink. The active bits are flip-flops cleared by reset, so no clearing
// pass is needed.
module event_timer_slot_pool #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], now_ms[34:3], time_value[66:35], absolute_mode[67],
  // repeat_flag[68], event_kind[69], slot_index[73:70], zeros above
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], result_slot[5:2], fired_kind[6], remaining_ms[38:7], zeros
  output logic [39:0] m_axis_tdata,
  // fired[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  etsp_pkg::state_e state_q, state_d;

  logic [31:0] repeat_q;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [2:0]  cmd_q;
  logic [31:0] now_q, tv_q;
  logic        absm_q, rep_q, kind_q;
  logic [3:0]  idx_q;
  logic [AW-1:0] ptr_q, ptr_d;

  logic        ovalid_q, ovalid_d;
  logic [1:0]  ost_q, ost_d;
  logic [3:0]  oslot_q, oslot_d;
  logic        ofired_q, ofired_d, okind_q, okind_d, olast_q, olast_d;
  logic [31:0] orem_q, orem_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  etsp_pkg::slot_t wrec, rrec;
  logic [etsp_pkg::SlotW-1:0] rdata;

  etsp_ram #(.Width(etsp_pkg::SlotW), .Depth(SLOT_COUNT)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrec),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );
  assign rrec = etsp_pkg::slot_t'(rdata);

  logic inrange, acc, out_free, last_ptr, due_hit;
  logic [AW-1:0] idx_a;
  assign inrange  = {28'd0, idx_q} < 32'(SLOT_COUNT);
  assign idx_a    = AW'(idx_q);
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign last_ptr = {{(32-AW){1'b0}}, ptr_q} == 32'(SLOT_COUNT - 1);
  assign due_hit  = active_q[ptr_q] && (now_q >= rrec.due);

  assign s_axis_tready = (state_q == etsp_pkg::S_IDLE) && !ovalid_q;
  assign raddr = (cmd_q == etsp_pkg::CMD_POLL) ? ptr_q : idx_a;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etsp_pkg::S_IDLE: if (acc) state_d = etsp_pkg::S_READ;
      etsp_pkg::S_READ: begin
        if (cmd_q == etsp_pkg::CMD_CREATE) begin
          state_d = etsp_pkg::S_OUT;
        end else if (cmd_q == etsp_pkg::CMD_POLL) begin
          state_d = etsp_pkg::S_SCAN;
        end else begin
          state_d = etsp_pkg::S_EXEC;
        end
      end
      etsp_pkg::S_EXEC: state_d = etsp_pkg::S_OUT;
      etsp_pkg::S_SCAN: begin
        if (!due_hit || out_free) begin
          if (last_ptr) state_d = etsp_pkg::S_OUT;
          else state_d = etsp_pkg::S_READ;
        end
      end
      etsp_pkg::S_OUT: if (out_free) state_d = etsp_pkg::S_IDLE;
      default: state_d = etsp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    active_d = active_q;
    ptr_d    = ptr_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ost_d    = ost_q;
    oslot_d  = oslot_q;
    ofired_d = ofired_q;
    okind_d  = okind_q;
    orem_d   = orem_q;
    olast_d  = olast_q;
    we       = 1'b0;
    waddr    = idx_a;
    wrec     = rrec;
    unique case (state_q)
      etsp_pkg::S_IDLE: ptr_d = '0;
      etsp_pkg::S_READ: begin
        // Create finds the lowest free slot from the active bits.
        if (cmd_q == etsp_pkg::CMD_CREATE) begin
          ost_d = etsp_pkg::ST_FULL;
          oslot_d = '0;
          for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!active_q[i]) begin
              ost_d = etsp_pkg::ST_OK;
              oslot_d = 4'(i);
              waddr = AW'(i);
            end
          end
          if (!absm_q && tv_q == '0) begin
            ost_d = etsp_pkg::ST_BAD;
            oslot_d = '0;
          end
          wrec.kind = kind_q;
          wrec.absolute = absm_q;
          wrec.recurring = rep_q;
          wrec.period = absm_q ? 32'd0 : tv_q;
          wrec.target = absm_q ? tv_q : 32'd0;
          wrec.due = absm_q ? tv_q : now_q + tv_q;
          if (ost_d == etsp_pkg::ST_OK) begin
            we = 1'b1;
            active_d[waddr] = 1'b1;
          end
          ofired_d = 1'b0;
          okind_d = 1'b0;
          orem_d = '0;
          olast_d = 1'b1;
        end
      end
      etsp_pkg::S_EXEC: begin
        ost_d = etsp_pkg::ST_OK;
        oslot_d = '0;
        ofired_d = 1'b0;
        okind_d = 1'b0;
        orem_d = '0;
        olast_d = 1'b1;
        unique case (cmd_q)
          etsp_pkg::CMD_DELETE: begin
            if (!inrange) ost_d = etsp_pkg::ST_BAD;
            else active_d[idx_a] = 1'b0;
          end
          etsp_pkg::CMD_RESTART: begin
            if (!inrange || !active_q[idx_a]) begin
              ost_d = etsp_pkg::ST_BAD;
            end else begin
              we = 1'b1;
              wrec.due = rrec.absolute ? rrec.target : now_q + rrec.period;
            end
          end
          etsp_pkg::CMD_QUERY: begin
            if (!inrange || !active_q[idx_a]) begin
              ost_d = etsp_pkg::ST_BAD;
            end else if (rrec.due > now_q) begin
              orem_d = rrec.due - now_q;
            end
          end
          default: ost_d = etsp_pkg::ST_BAD;
        endcase
      end
      etsp_pkg::S_SCAN: begin
        waddr = ptr_q;
        if (due_hit && out_free) begin
          ovalid_d = 1'b1;
          ost_d = etsp_pkg::ST_OK;
          oslot_d = 4'(ptr_q);
          ofired_d = 1'b1;
          okind_d = rrec.kind;
          orem_d = '0;
          olast_d = 1'b0;
          if (rrec.recurring) begin
            we = 1'b1;
            if (rrec.absolute) begin
              wrec.target = rrec.target + repeat_q;
              wrec.due = rrec.target + repeat_q;
            end else begin
              wrec.due = now_q + rrec.period;
            end
          end else begin
            active_d[ptr_q] = 1'b0;
          end
        end
        if ((!due_hit || out_free) && !last_ptr) ptr_d = ptr_q + 1'b1;
        if (last_ptr) begin
          // Closing result is set up in S_OUT.
        end
      end
      etsp_pkg::S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (cmd_q == etsp_pkg::CMD_POLL) begin
            ost_d = etsp_pkg::ST_OK;
            oslot_d = '0;
            ofired_d = 1'b0;
            okind_d = 1'b0;
            orem_d = '0;
          end
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= etsp_pkg::S_IDLE;
      repeat_q <= 32'd1000;
      active_q <= '0;
      ovalid_q <= 1'b0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      ptr_q    <= ptr_d;
      if (cfg_we_i) repeat_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q  <= s_axis_tdata[2:0];
      now_q  <= s_axis_tdata[34:3];
      tv_q   <= s_axis_tdata[66:35];
      absm_q <= s_axis_tdata[67];
      rep_q  <= s_axis_tdata[68];
      kind_q <= s_axis_tdata[69];
      idx_q  <= s_axis_tdata[73:70];
    end
    ost_q    <= ost_d;
    oslot_q  <= oslot_d;
    ofired_q <= ofired_d;
    okind_q  <= okind_d;
    orem_q   <= orem_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, orem_q, okind_q, oslot_q, ost_q};
  assign m_axis_tuser  = ofired_q;
  assign m_axis_tlast  = olast_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ovalid_q)
    else $error("input taken while a result is pending");
  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ofired_q) |-> !olast_q)
    else $error("fired result marked last");
  a_scan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == etsp_pkg::S_SCAN) |-> (cmd_q == etsp_pkg::CMD_POLL))
    else $error("scan outside poll");

endmodule
